>>> hdl/s7c_pkg.sv
// Shared types and constants for the seven-bit system-exclusive codec.
// No dependencies.
`timescale 1ns / 1ps
package s7c_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned GROUP_LEN = 7;
  localparam logic [2:0]  GROUP_LAST_IDX = 3'(GROUP_LEN - 1);
  localparam logic [7:0]  LOW7_MASK = 8'h7F;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // One request from the front to the back.
  typedef struct packed {
    logic       emit;   // single finished byte (unpack data)
    logic       close;  // pack: this byte closes the group
    logic       last;   // source byte was marked last
    logic [2:0] idx;    // pack: slot of this byte in the group
    logic [7:0] data;
  } s7c_op_t;

endpackage

>>> hdl/s7c_front.sv
// Front end: accepts source bytes, tracks group position, header and direction.
// Depends on s7c_pkg.
`timescale 1ns / 1ps
module s7c_front
  import s7c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in_message,
  input  logic       q_full,
  output logic       q_push,
  output s7c_op_t    q_op
);

  logic       direction;
  logic [2:0] group_count;
  logic [6:0] top_bit_header;
  logic       header_seen;

  logic [2:0] slot;
  logic [2:0] slot_inc;
  logic       closing;
  logic       is_header;
  logic       accept;

  assign cfg_ready = !rst;
  assign in_ready  = !q_full && !rst;
  assign accept    = in_valid && in_ready;
  assign is_header = (direction == DIR_UNPACK) && !header_seen;

  always_comb begin
    slot     = (group_count > GROUP_LAST_IDX) ? 3'd0 : group_count;
    slot_inc = slot + 3'd1;
    closing  = (slot == GROUP_LAST_IDX) || last_in_message;
  end

  always_comb begin
    q_op.emit  = (direction == DIR_UNPACK);
    q_op.close = closing;
    q_op.last  = last_in_message;
    q_op.idx   = slot;
    q_op.data  = data_byte;
    if (direction == DIR_UNPACK) begin
      q_op.data = data_byte | {top_bit_header[slot], 7'd0};
    end
  end

  assign q_push = accept && !is_header;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIR_PACK;
      group_count    <= 3'd0;
      top_bit_header <= 7'd0;
      header_seen    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction      <= cfg_data;
      group_count    <= 3'd0;
      top_bit_header <= 7'd0;
      header_seen    <= 1'b0;
    end else if (accept) begin
      if (direction == DIR_PACK) begin
        group_count <= closing ? 3'd0 : slot_inc;
      end else if (!header_seen) begin
        top_bit_header <= data_byte[6:0];
        group_count    <= 3'd0;
        header_seen    <= !last_in_message;
      end else if (closing) begin
        group_count <= 3'd0;
        header_seen <= 1'b0;
      end else begin
        group_count <= slot_inc;
      end
    end
  end

endmodule

>>> hdl/s7c_fifo.sv
// Short request queue between the front end and the back end.
// Depends on s7c_pkg.
`timescale 1ns / 1ps
module s7c_fifo
  import s7c_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  s7c_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output s7c_op_t head_op
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  s7c_op_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_MAX);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/s7c_back.sv
// Back end: holds the pack group, emits header and data bytes into the output register.
// Depends on s7c_pkg.
`timescale 1ns / 1ps
module s7c_back
  import s7c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  s7c_op_t    q_op,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_end
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state;
  logic [7:0] group_bytes [GROUP_LEN];
  logic [2:0] group_size;
  logic       group_last;
  logic [2:0] rd_idx;

  logic       load;
  logic       fire;
  logic       rd_end;
  logic [6:0] header;

  assign load   = !out_valid || out_ready;
  assign fire   = load && ((state == ST_IDLE && !q_empty && q_op.emit) ||
                           state == ST_HDR || state == ST_DATA);
  assign rd_end = (rd_idx == group_size - 3'd1);

  always_comb begin
    for (int i = 0; i < GROUP_LEN; i++) begin
      header[i] = group_bytes[i][7] && (3'(i) < group_size);
    end
  end

  always_comb begin
    q_pop = 1'b0;
    if (state == ST_IDLE && !q_empty) begin
      q_pop = q_op.emit ? load : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !q_empty && !q_op.emit) begin
      group_bytes[q_op.idx] <= q_op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      group_size <= 3'd0;
      group_last <= 1'b0;
      rd_idx     <= 3'd0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_op.emit) begin
              if (load) begin
                out_byte    <= q_op.data;
                run_last    <= 1'b1;
                message_end <= q_op.last;
              end
            end else if (q_op.close) begin
              group_size <= q_op.idx + 3'd1;
              group_last <= q_op.last;
              state      <= ST_HDR;
            end
          end
        end
        ST_HDR: begin
          if (load) begin
            out_byte    <= {1'b0, header};
            run_last    <= 1'b0;
            message_end <= 1'b0;
            rd_idx      <= 3'd0;
            state       <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (load) begin
            out_byte    <= group_bytes[rd_idx] & LOW7_MASK;
            run_last    <= rd_end;
            message_end <= rd_end && group_last;
            rd_idx      <= rd_idx + 3'd1;
            if (rd_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sysex_seven_bit_codec.sv
// MIDI system-exclusive 8-to-7-bit codec, both directions selected by one register.
// Input bytes in on a valid/ready channel, converted bytes out on another.
// Write the direction bit on the config channel (ready except in reset) only while
// idle; each write also drops any partial group. 0 packs, 1 unpacks.
// Pack: every accepted byte passes through the request queue to the back end.
// The seventh byte, or a byte marked last, closes the group; the back end then
// sends the header and the group's bytes masked to seven bits, one per cycle
// while the receiver is ready, taking no new request meanwhile.
// Unpack: a header byte produces nothing; each data byte produces one result
// with its top bit restored, at up to one item per cycle.
// Results sit in an output register; a stalled receiver holds it, and input
// keeps flowing until the request queue fills (QUEUE_DEPTH entries).
// Reset (rst, synchronous) selects pack and empties the queue and group state.
// Depends on s7c_pkg, s7c_front, s7c_fifo, s7c_back.
`timescale 1ns / 1ps
module sysex_seven_bit_codec
  import s7c_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_end
);

  logic    q_full;
  logic    q_push;
  s7c_op_t q_push_op;
  logic    q_pop;
  logic    q_empty;
  s7c_op_t q_head_op;

  s7c_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_in_message (last_in_message),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_op            (q_push_op)
  );

  s7c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_op (q_head_op)
  );

  s7c_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_op        (q_head_op),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .message_end (message_end)
  );

endmodule
